// File: src/sai_pkg.sv
// ----------------------------------------------------------------------------
// sai_pkg
// Shared types and constants for the shifting array with insert and delete.
// ----------------------------------------------------------------------------
package sai_pkg;

   localparam int DEPTH_DEF = 16;
   localparam int FUNC_W    = 2;
   localparam int POS_W     = 4;
   localparam int DATA_W    = 32;
   localparam int LENGTH_W  = 5;
   localparam int STATUS_W  = 2;

   typedef enum logic [FUNC_W-1:0] {
      FN_INSERT = 2'd0,
      FN_DELETE = 2'd1,
      FN_GET    = 2'd2,
      FN_SWAP   = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // what every cell of the row does in a cycle
   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_DELETE = 2'd2,
      CELL_SWAP   = 2'd3
   } cell_op_type;

   typedef struct packed {
      cell_op_type              op;
      logic [POS_W-1:0]         pos;
      logic [POS_W-1:0]         pos2;
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] value2;
   } cell_cmd_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_SWAP = 1'b1
   } state_type;

endpackage

// File: src/sai_req_if.sv
// ----------------------------------------------------------------------------
// sai_req_if
// Request channel: operation, positions and value with valid/ready.
// ----------------------------------------------------------------------------
interface sai_req_if
   import sai_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic [FUNC_W-1:0]        func;
   logic [POS_W-1:0]         position;
   logic [POS_W-1:0]         second_position;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, func, position, second_position, value, input ready);
   modport sink   (input valid, func, position, second_position, value, output ready);
endinterface

// File: src/sai_rsp_if.sv
// ----------------------------------------------------------------------------
// sai_rsp_if
// Response channel: data, new length and status with valid/ready.
// ----------------------------------------------------------------------------
interface sai_rsp_if
   import sai_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] data;
   logic [LENGTH_W-1:0]      length;
   logic [STATUS_W-1:0]      status;

   modport source (output valid, data, length, status, input ready);
   modport sink   (input valid, data, length, status, output ready);
endinterface

// File: src/shifting_array_insert_delete.sv
// Order: insert, delete and get answer in the cycle after acceptance; a valid swap
//   reads the first entry, then reads the second and writes both in the S_SWAP state.
// Throughput: one word per cycle while the response is not held; a swap blocks new
//   requests in S_SWAP, since the single read port onto the cell row reads one entry.
// Reset: synchronous, clears the state, the length and the response valid; cell contents
//   stay as they are and are read only after being written.
// ----------------------------------------------------------------------------
// shifting_array_insert_delete
// Ordered array of cells with a length register; insert, delete, get and swap.
// ----------------------------------------------------------------------------
module shifting_array_insert_delete
   import sai_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   sai_req_if.sink   req_chan,
   sai_rsp_if.source rsp_chan
);

   localparam int LEN_W = $clog2(DEPTH + 1);

   logic signed [DATA_W-1:0] q [DEPTH];
   cell_cmd_type             cmd;

   state_type                state_ff, state_in;
   logic [LEN_W-1:0]         fill_ff, fill_in;
   logic [POS_W-1:0]         pa_ff, pa_in;
   logic [POS_W-1:0]         pb_ff, pb_in;
   logic signed [DATA_W-1:0] temp_ff, temp_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [LENGTH_W-1:0]      rsp_length_ff, rsp_length_in;
   status_type               rsp_status_ff, rsp_status_in;

   logic [POS_W-1:0]         rd_addr;
   logic signed [DATA_W-1:0] rd_data;
   logic                     out_free;
   logic                     accept;
   logic                     pa_out;
   logic                     pb_out;

   // row of cells, each shifting from its neighbors
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [DATA_W-1:0] lower_q;
      logic signed [DATA_W-1:0] upper_q;
      if (i == 0) begin : g_first
         assign lower_q = '0;
      end else begin : g_lower
         assign lower_q = q[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign upper_q = '0;
      end else begin : g_upper
         assign upper_q = q[i+1];
      end
      sai_cell #(
         .IDX (i)
      ) u_cell (
         .clock   (clock),
         .cmd     (cmd),
         .lower_q (lower_q),
         .upper_q (upper_q),
         .q       (q[i])
      );
   end

   // single read port onto the row
   assign rd_addr = (state_ff == S_SWAP) ? pb_ff : req_chan.position;

   always_comb begin
      rd_data = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (int'(rd_addr) == i) begin
            rd_data = q[i];
         end
      end
   end

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE) && out_free;
   assign accept = req_chan.valid && req_chan.ready;
   assign pa_out = int'(req_chan.position) >= int'(fill_ff);
   assign pb_out = int'(req_chan.second_position) >= int'(fill_ff);

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      pa_in         = pa_ff;
      pb_in         = pb_ff;
      temp_in       = temp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      cmd.op        = CELL_HOLD;
      cmd.pos       = req_chan.position;
      cmd.pos2      = req_chan.second_position;
      cmd.value     = req_chan.value;
      cmd.value2    = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = '0;
               rsp_status_in = ST_OK;
               case (func_type'(req_chan.func))
                  FN_INSERT: begin
                     if (fill_ff == LEN_W'(DEPTH)) begin
                        rsp_status_in = ST_FULL;
                     end else if (int'(req_chan.position) > int'(fill_ff)) begin
                        rsp_status_in = ST_RANGE;
                     end else begin
                        cmd.op  = CELL_INSERT;
                        fill_in = fill_ff + LEN_W'(1);
                     end
                  end
                  FN_DELETE: begin
                     if (pa_out) begin
                        rsp_status_in = ST_RANGE;
                     end else begin
                        rsp_data_in = rd_data;
                        cmd.op      = CELL_DELETE;
                        fill_in     = fill_ff - LEN_W'(1);
                     end
                  end
                  FN_GET: begin
                     if (pa_out) begin
                        rsp_status_in = ST_RANGE;
                     end else begin
                        rsp_data_in = rd_data;
                     end
                  end
                  FN_SWAP: begin
                     if (pa_out || pb_out) begin
                        rsp_status_in = ST_RANGE;
                     end else begin
                        // first entry now, second one next cycle
                        rsp_valid_in = 1'b0;
                        temp_in      = rd_data;
                        pa_in        = req_chan.position;
                        pb_in        = req_chan.second_position;
                        state_in     = S_SWAP;
                     end
                  end
                  default: begin
                     rsp_status_in = ST_OK;
                  end
               endcase
            end
         end
         S_SWAP: begin
            if (out_free) begin
               cmd.op        = CELL_SWAP;
               cmd.pos       = pa_ff;
               cmd.pos2      = pb_ff;
               cmd.value     = rd_data;
               cmd.value2    = temp_ff;
               rsp_valid_in  = 1'b1;
               rsp_data_in   = '0;
               rsp_status_in = ST_OK;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_length_in = LENGTH_W'(fill_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pa_ff         <= pa_in;
      pb_ff         <= pb_in;
      temp_ff       <= temp_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_length_ff <= rsp_length_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.data   = rsp_data_ff;
   assign rsp_chan.length = rsp_length_ff;
   assign rsp_chan.status = rsp_status_ff;

endmodule

// File: src/sai_cell.sv
// ----------------------------------------------------------------------------
// sai_cell
// One entry of the array; loads a new value, shifts from a neighbor or holds.
// ----------------------------------------------------------------------------
module sai_cell
   import sai_pkg::*;
#(
   parameter int IDX = 0
) (
   input  logic                     clock,
   input  cell_cmd_type             cmd,
   input  logic signed [DATA_W-1:0] lower_q,
   input  logic signed [DATA_W-1:0] upper_q,
   output logic signed [DATA_W-1:0] q
);

   logic signed [DATA_W-1:0] q_ff;
   logic signed [DATA_W-1:0] q_in;

   always_comb begin
      q_in = q_ff;
      case (cmd.op)
         CELL_INSERT: begin
            if (int'(cmd.pos) == IDX) begin
               q_in = cmd.value;
            end else if (IDX > int'(cmd.pos)) begin
               q_in = lower_q;
            end
         end
         CELL_DELETE: begin
            // entries past the length take garbage, they are never read
            if (IDX >= int'(cmd.pos)) begin
               q_in = upper_q;
            end
         end
         CELL_SWAP: begin
            if (int'(cmd.pos) == IDX) begin
               q_in = cmd.value;
            end else if (int'(cmd.pos2) == IDX) begin
               q_in = cmd.value2;
            end
         end
         default: begin
            q_in = q_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   assign q = q_ff;

endmodule
